// ===== src/ordered_list_position_engine_assert.svh =====
// Assertion macros used by the top RTL file of the ordered list engine.
`ifndef ORDERED_LIST_POSITION_ENGINE_ASSERT_SVH
`define ORDERED_LIST_POSITION_ENGINE_ASSERT_SVH

// A property checked at every rising clock edge outside reset.
`define OLPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define OLPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  `OLPE_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== src/olpe_pkg.sv =====
package olpe_pkg;

  localparam int DEPTH       = 64;
  localparam int VAL_W       = 32;
  localparam int POS_W       = 8;
  localparam int OP_W        = 4;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int IN_TDATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CNT_W + 2 + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_BACK  = 4'd1,
    OP_DEL_FRONT = 4'd2,
    OP_DEL_BACK  = 4'd3,
    OP_INS_POS   = 4'd4,
    OP_DEL_POS   = 4'd5,
    OP_INS_MID   = 4'd6,
    OP_DEL_MID   = 4'd7,
    OP_MID_FRONT = 4'd8,
    OP_MID_BACK  = 4'd9,
    OP_SEARCH    = 4'd10,
    OP_COUNT     = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_SHR,
    MODE_SHL
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [IDX_W-1:0]   lo;
    logic [IDX_W-1:0]   hi;
    logic [VAL_W-1:0]   ld_value;
  } shift_t;

  typedef struct packed {
    shift_t             shift;
    logic               upd;
    logic               cap;
    logic [VAL_W-1:0]   key;
    logic [CNT_W-1:0]   count;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic               dropped;
    logic               search;
  } dec_res_t;

endpackage

// ===== src/olpe_cell.sv =====
module olpe_cell
  import olpe_pkg::*;
(
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [VAL_W-1:0]  left_i,
  input  logic [VAL_W-1:0]  right_i,
  output logic [VAL_W-1:0]  value_o,
  output logic              hit_o
);

  logic [VAL_W-1:0] value_q, value_d;
  logic             hit_q;

  always_comb begin
    value_d = value_q;
    case (ctrl_i.shift.mode)
      MODE_SHR: begin
        if (idx_i == ctrl_i.shift.lo) begin
          value_d = ctrl_i.shift.ld_value;
        end else if (idx_i > ctrl_i.shift.lo && idx_i <= ctrl_i.shift.hi) begin
          value_d = left_i;
        end
      end
      MODE_SHL: begin
        if (idx_i == ctrl_i.shift.hi) begin
          value_d = ctrl_i.shift.ld_value;
        end else if (idx_i >= ctrl_i.shift.lo && idx_i < ctrl_i.shift.hi) begin
          value_d = right_i;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd) begin
      value_q <= value_d;
    end
    if (ctrl_i.cap) begin
      hit_q <= (value_q == ctrl_i.key) && (CNT_W'(idx_i) < ctrl_i.count);
    end
  end

  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

// ===== src/olpe_dec.sv =====
module olpe_dec
  import olpe_pkg::*;
(
  input  op_e               op_i,
  input  logic [VAL_W-1:0]  value_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [VAL_W-1:0]  mid_value_i,
  output logic [IDX_W-1:0]  mid_idx_o,
  output shift_t            shift_o,
  output dec_res_t          res_o
);

  function automatic logic [CMP_W-1:0] pos_index(input logic [CMP_W-1:0] p,
                                                 input logic [CMP_W-1:0] n);
    logic [CMP_W-1:0] r;
    if (p <= CMP_W'(1)) begin
      r = '0;
    end else if (p > n) begin
      r = n;
    end else begin
      r = p - CMP_W'(1);
    end
    return r;
  endfunction

  logic [CMP_W-1:0] n, n_m1, mid, k_pos, k_mid, ins_k, rm_k, rm_raw;
  logic             full, nz, two;
  logic             ins_req, rm_req, mv_front, mv_back, search;

  always_comb begin
    n      = CMP_W'(count_i);
    n_m1   = n - CMP_W'(1);
    mid    = (n + CMP_W'(1)) >> 1;
    full   = n >= CMP_W'(DEPTH);
    nz     = n != '0;
    two    = n >= CMP_W'(2);
    k_pos  = pos_index(CMP_W'(position_i), n);
    k_mid  = pos_index(mid + CMP_W'(1), n);
    mid_idx_o = (mid == '0) ? '0 : IDX_W'(mid - CMP_W'(1));

    ins_req  = 1'b0;
    rm_req   = 1'b0;
    mv_front = 1'b0;
    mv_back  = 1'b0;
    search   = 1'b0;
    ins_k    = '0;
    rm_raw   = '0;

    unique case (op_i)
      OP_INS_FRONT: begin ins_req = 1'b1; ins_k = '0; end
      OP_INS_BACK:  begin ins_req = 1'b1; ins_k = n; end
      OP_DEL_FRONT: begin rm_req = 1'b1; rm_raw = '0; end
      OP_DEL_BACK:  begin rm_req = 1'b1; rm_raw = n_m1; end
      OP_INS_POS:   begin ins_req = 1'b1; ins_k = k_pos; end
      OP_DEL_POS:   begin rm_req = 1'b1; rm_raw = k_pos; end
      OP_INS_MID:   begin ins_req = 1'b1; ins_k = k_mid; end
      OP_DEL_MID:   begin rm_req = 1'b1; rm_raw = k_mid; end
      OP_MID_FRONT: mv_front = 1'b1;
      OP_MID_BACK:  mv_back = 1'b1;
      OP_SEARCH:    search = 1'b1;
      default:      search = 1'b0;
    endcase

    rm_k = (rm_raw >= n) ? n_m1 : rm_raw;

    shift_o.mode     = MODE_HOLD;
    shift_o.lo       = '0;
    shift_o.hi       = '0;
    shift_o.ld_value = value_i;
    res_o.count      = count_i;
    res_o.dropped    = 1'b0;
    res_o.search     = search;

    if (ins_req) begin
      if (full) begin
        res_o.dropped = 1'b1;
      end else begin
        shift_o.mode = MODE_SHR;
        shift_o.lo   = IDX_W'(ins_k);
        shift_o.hi   = IDX_W'(n);
        res_o.count  = CNT_W'(n + CMP_W'(1));
      end
    end
    if (rm_req && nz) begin
      shift_o.mode = MODE_SHL;
      shift_o.lo   = IDX_W'(rm_k);
      shift_o.hi   = IDX_W'(n_m1);
      res_o.count  = CNT_W'(n_m1);
    end
    if (mv_front && two) begin
      shift_o.mode     = MODE_SHR;
      shift_o.lo       = '0;
      shift_o.hi       = mid_idx_o;
      shift_o.ld_value = mid_value_i;
    end
    if (mv_back && two) begin
      shift_o.mode     = MODE_SHL;
      shift_o.lo       = mid_idx_o;
      shift_o.hi       = IDX_W'(n_m1);
      shift_o.ld_value = mid_value_i;
    end
  end

endmodule

// ===== src/ordered_list_position_engine.sv =====
// Channel   Direction  Payload
// s_axis    in         tuser: op; tdata: item_value, position
// m_axis    out        tdata: entry_count, found, dropped
//
// One command is taken per cycle while the result is not stalled; its result passes through the first and second stage.
// Every cell shifts, loads or holds in the cycle of the transfer; the match flags of
// the cells are gathered in the second stage.
// The asynchronous reset empties the list; no clearing pass follows it.
// A stalled result holds both stages and the input channel together.
`include "ordered_list_position_engine_assert.svh"

module ordered_list_position_engine
  import olpe_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [IN_TDATA_W-1:0]   s_axis_tdata,  // item_value, position
  input  logic [OP_W-1:0]         s_axis_tuser,  // op
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata   // entry_count, found, dropped
);

  logic [CNT_W-1:0] count_q;
  logic             valid_a_q, valid_b_q;
  logic [CNT_W-1:0] count_a_q, count_b_q;
  logic             dropped_a_q, dropped_b_q, search_a_q, found_b_q;
  logic             en, acc;
  logic [VAL_W-1:0] item_value;
  logic [POS_W-1:0] position;
  logic [IDX_W-1:0] mid_idx;
  shift_t           shift;
  dec_res_t         res;
  cell_ctrl_t       ctrl;
  logic [VAL_W-1:0] vals    [DEPTH];
  logic [VAL_W-1:0] left_w  [DEPTH];
  logic [VAL_W-1:0] right_w [DEPTH];
  logic [DEPTH-1:0] hits;

  assign item_value    = s_axis_tdata[VAL_W-1:0];
  assign position      = s_axis_tdata[VAL_W+POS_W-1:VAL_W];
  assign en            = !valid_b_q || m_axis_tready;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;

  olpe_dec u_dec (
    .op_i        (op_e'(s_axis_tuser)),
    .value_i     (item_value),
    .position_i  (position),
    .count_i     (count_q),
    .mid_value_i (vals[mid_idx]),
    .mid_idx_o   (mid_idx),
    .shift_o     (shift),
    .res_o       (res)
  );

  always_comb begin
    ctrl.shift = shift;
    ctrl.upd   = acc;
    ctrl.cap   = en;
    ctrl.key   = item_value;
    ctrl.count = count_q;
    if (!acc) begin
      ctrl.shift.mode = MODE_HOLD;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = '0;
    end else begin : g_mid_l
      assign left_w[g] = vals[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w[g] = '0;
    end else begin : g_mid_r
      assign right_w[g] = vals[g+1];
    end
    olpe_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(g)),
      .ctrl_i  (ctrl),
      .left_i  (left_w[g]),
      .right_i (right_w[g]),
      .value_o (vals[g]),
      .hit_o   (hits[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (acc) begin
        count_q <= res.count;
      end
      if (en) begin
        valid_a_q <= s_axis_tvalid;
        valid_b_q <= valid_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      count_a_q   <= res.count;
      dropped_a_q <= res.dropped;
      search_a_q  <= res.search;
      count_b_q   <= count_a_q;
      dropped_b_q <= dropped_a_q;
      found_b_q   <= search_a_q && (|hits);
    end
  end

  assign m_axis_tvalid = valid_b_q;
  assign m_axis_tdata  = OUT_TDATA_W'({dropped_b_q, found_b_q, count_b_q});

  `OLPE_ASSERT(a_count_max, count_q <= CNT_W'(DEPTH), "Entry count above list depth.")
  `OLPE_ASSERT_NEXT(a_count_hold, !acc, $stable(count_q), "Count moved without a transfer.")
  `OLPE_ASSERT_NEXT(a_drop_full, acc && res.dropped,
                    count_q == CNT_W'(DEPTH) && $stable(count_q),
                    "Dropped insert changed a list that was not full.")
  `OLPE_ASSERT_NEXT(a_stage_a, acc && res.dropped, valid_a_q && dropped_a_q,
                    "Dropped flag lost on its way into the first stage.")

endmodule
